FILE: hw/rtl/i2cts_pkg.sv
// Package with the beat types and the item codes of the temperature sensor block.
`default_nettype none

package i2cts_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [7:0] CHIP_ID_RESET = 8'hA1;
    localparam logic [ADDR_W-3:0] REG_CHIP_ID = '0;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_CONVERT = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               is_read;
        logic [7:0]         write_byte;
        logic signed [15:0] temperature_sample;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       os_pull_low;
    } t_out_beat;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cts_apb.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module i2cts_apb (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [i2cts_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [i2cts_pkg::DATA_W-1:0]  pwdata,
    output logic      [i2cts_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    output logic      [7:0]                    o_chip_id
);
    import i2cts_pkg::*;

    logic [7:0] r_chip_id;
    logic       hit;

    assign hit = (paddr[ADDR_W-1:2] == REG_CHIP_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_id <= CHIP_ID_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_chip_id <= pwdata[7:0];
        end
    end

    assign prdata    = hit ? {{(DATA_W-8){1'b0}}, r_chip_id} : '0;
    assign pready    = 1'b1;
    assign o_chip_id = r_chip_id;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cts_core.sv
// Sensor register state, bus byte handling and thermostat update for one item.
`default_nettype none

module i2cts_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire i2cts_pkg::t_in_beat  i_item,
    input  wire logic [7:0]           i_chip_id,
    output i2cts_pkg::t_out_beat      o_result
);
    import i2cts_pkg::*;

    localparam logic [7:0] RG_TEMP = 8'd0;
    localparam logic [7:0] RG_MODE = 8'd1;
    localparam logic [7:0] RG_HYST = 8'd2;
    localparam logic [7:0] RG_OS   = 8'd3;
    localparam logic [7:0] RG_ID   = 8'd7;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_RD1  = 3'd1,
        PH_RD2  = 3'd2,
        PH_WR1  = 3'd3,
        PH_WR2  = 3'd4,
        PH_WR3  = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_ptr, n_ptr;
    logic [15:0] r_temp, n_temp;
    logic [7:0]  r_mode, n_mode;
    logic [15:0] r_ot, n_ot;
    logic [15:0] r_hy, n_hy;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_rel, n_rel;
    logic        r_th, n_th;
    logic        r_tl, n_tl;
    logic        r_pin, n_pin;

    logic [7:0]  rd;
    logic [7:0]  d;
    logic [2:0]  cnt_dec;
    logic [2:0]  new_rel;
    logic        hot;
    logic        cold;

    assign d       = i_item.write_byte;
    assign cnt_dec = r_cnt - 3'd1;
    assign new_rel = (d[4:3] == 2'd0) ? 3'd1 : {d[4:3], 1'b0};
    assign hot     = i_item.temperature_sample > $signed(r_ot);
    assign cold    = i_item.temperature_sample < $signed(r_hy);

    always_comb begin
        n_phase = r_phase;
        n_ptr   = r_ptr;
        n_temp  = r_temp;
        n_mode  = r_mode;
        n_ot    = r_ot;
        n_hy    = r_hy;
        n_cnt   = r_cnt;
        n_rel   = r_rel;
        n_th    = r_th;
        n_tl    = r_tl;
        n_pin   = r_pin;
        rd      = '0;
        case (i_item.opcode)
            OP_START: begin
                n_phase = i_item.is_read ? PH_RD1 : PH_WR1;
            end
            OP_WRITE: begin
                case (r_phase)
                    PH_WR1: begin
                        n_ptr   = d;
                        n_phase = PH_WR2;
                    end
                    PH_WR2: begin
                        n_phase = PH_IDLE;
                        if (r_ptr == RG_MODE) begin
                            n_mode = d;
                            if (d[1:0] != 2'd0) begin
                                n_pin = d[2];
                            end
                            n_rel = new_rel;
                            n_cnt = new_rel;
                        end else if (r_ptr == RG_OS) begin
                            n_ot    = {d, r_ot[7:0]};
                            n_phase = PH_WR3;
                        end else if (r_ptr == RG_HYST) begin
                            n_hy    = {d, r_hy[7:0]};
                            n_phase = PH_WR3;
                        end
                    end
                    PH_WR3: begin
                        n_phase = PH_IDLE;
                        if (r_ptr == RG_OS) begin
                            n_ot = {r_ot[15:8], d};
                        end else if (r_ptr == RG_HYST) begin
                            n_hy = {r_hy[15:8], d};
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            OP_READ: begin
                if (r_mode[1]) begin
                    n_pin = r_mode[2];
                end
                n_phase = PH_IDLE;
                case (r_phase)
                    PH_RD1: begin
                        if (r_ptr == RG_TEMP) begin
                            rd      = r_temp[15:8];
                            n_phase = PH_RD2;
                        end else if (r_ptr == RG_MODE) begin
                            rd = r_mode;
                        end else if (r_ptr == RG_OS) begin
                            rd      = r_ot[15:8];
                            n_phase = PH_RD2;
                        end else if (r_ptr == RG_HYST) begin
                            rd      = r_hy[15:8];
                            n_phase = PH_RD2;
                        end else if (r_ptr == RG_ID) begin
                            rd = i_chip_id;
                        end
                    end
                    PH_RD2: begin
                        if (r_ptr == RG_TEMP) begin
                            rd = r_temp[7:0];
                        end else if (r_ptr == RG_OS) begin
                            rd = r_ot[7:0];
                        end else if (r_ptr == RG_HYST) begin
                            rd = r_hy[7:0];
                        end
                    end
                    default: begin
                        rd = '0;
                    end
                endcase
            end
            default: begin
                if (r_phase == PH_IDLE) begin
                    n_temp = i_item.temperature_sample;
                    if (!r_mode[0]) begin
                        n_cnt = r_rel;
                        if (hot) begin
                            n_cnt = cnt_dec;
                            if (cnt_dec == 3'd0) begin
                                if (r_mode[1]) begin
                                    if (!r_th) begin
                                        n_pin = !r_mode[2];
                                        n_th  = 1'b1;
                                        n_tl  = 1'b0;
                                    end
                                end else begin
                                    n_pin = !r_mode[2];
                                end
                                n_cnt = r_rel;
                            end
                        end else if (cold) begin
                            if (r_mode[1]) begin
                                if (!r_tl) begin
                                    n_pin = !r_mode[2];
                                    n_tl  = 1'b1;
                                    n_th  = 1'b0;
                                end
                            end else begin
                                n_pin = r_mode[2];
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ptr   <= '0;
            r_temp  <= '0;
            r_mode  <= '0;
            r_ot    <= 16'h5000;
            r_hy    <= 16'h4B00;
            r_cnt   <= 3'd1;
            r_rel   <= 3'd1;
            r_th    <= 1'b0;
            r_tl    <= 1'b0;
            r_pin   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_ptr   <= n_ptr;
            r_temp  <= n_temp;
            r_mode  <= n_mode;
            r_ot    <= n_ot;
            r_hy    <= n_hy;
            r_cnt   <= n_cnt;
            r_rel   <= n_rel;
            r_th    <= n_th;
            r_tl    <= n_tl;
            r_pin   <= n_pin;
        end
    end

    assign o_result.read_data   = rd;
    assign o_result.os_pull_low = n_pin;

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_temperature_sensor_thermostat.sv
// Top level of the temperature sensor register block with thermostat output.
//
// Input beats carry a bus start, a written byte, a read request or a
// conversion with a signed 8.8 temperature sample. Every input beat gives
// exactly one output beat with the read byte (zero unless a read) and the
// level of the alert pin after the item is applied.
// An accepted beat lands in an input register; once the output register can
// take a result, the register state and the result are updated together, and
// the result sits in the output register from then on. One beat is accepted
// per cycle unless the input stalls.
// When the receiver stalls, the output register holds its beat and the input
// register keeps taking one more beat, after which the input stalls too.
// Reset is synchronous and brings back the power-on register values with the
// alert pin released. The identification byte is written over the APB-style
// port only while no beat is in flight; this is a rule for the user, and the
// block itself does not enforce it.
`default_nettype none

module i2c_temperature_sensor_thermostat (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire i2cts_pkg::t_in_beat           i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output i2cts_pkg::t_out_beat               o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [i2cts_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [i2cts_pkg::DATA_W-1:0]  pwdata,
    output logic      [i2cts_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);
    import i2cts_pkg::*;

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;
    t_out_beat  result;
    logic       advance;
    logic       fire;
    logic       in_take;
    logic [7:0] chip_id;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    i2cts_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_chip_id (chip_id)
    );

    i2cts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_chip_id (chip_id),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted beat did not reach the input register");

    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed beat did not reach the output register");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in.opcode != OP_READ)) |=> (o_out_data.read_data == 8'd0))
        else $error("non-read beat returned nonzero data");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !fire)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the temperature sensor register block with thermostat output.
import i2cts_pkg::*;

localparam logic [7:0] PTR_TEMP = 8'd0;
localparam logic [7:0] PTR_MODE = 8'd1;
localparam logic [7:0] PTR_HYST = 8'd2;
localparam logic [7:0] PTR_OS   = 8'd3;
localparam logic [7:0] PTR_ID   = 8'd7;

localparam int MODE_SHUTDOWN  = 0;
localparam int MODE_INTERRUPT = 1;
localparam int MODE_POLARITY  = 2;

typedef enum logic [2:0] {PH_IDLE, PH_RD1, PH_RD2, PH_WR1, PH_WR2, PH_WR3} bus_phase_e;

class sensor_scoreboard;
    logic [7:0]  chip_id;
    bus_phase_e  phase;
    logic [7:0]  pointer;
    logic [15:0] temp_value;
    logic [7:0]  mode;
    logic [15:0] ot_limit;
    logic [15:0] hyst_limit;
    logic [2:0]  fault_cnt;
    logic [2:0]  fault_reload;
    bit          tripped_high;
    bit          tripped_low;
    bit          pin_low;
    t_out_beat   pending_results[$];
    int unsigned errors;

    function new();
        errors = 0;
        chip_id = CHIP_ID_RESET;
        phase = PH_IDLE;
        pointer = 8'h00;
        temp_value = 16'h0000;
        mode = 8'h00;
        ot_limit = 16'h5000;
        hyst_limit = 16'h4B00;
        fault_cnt = 3'd1;
        fault_reload = 3'd1;
        tripped_high = 1'b0;
        tripped_low = 1'b0;
        pin_low = 1'b0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void drive_alert(bit active);
        pin_low = active ? !mode[MODE_POLARITY] : mode[MODE_POLARITY];
    endfunction

    function void load_fault_queue();
        logic [2:0] r;
        r = {mode[4:3], 1'b0};
        if (r == 3'd0) r = 3'd1;
        fault_reload = r;
        fault_cnt = r;
    endfunction

    function void take_write(logic [7:0] d);
        case (phase)
            PH_WR1: begin
                pointer = d;
                phase = PH_WR2;
            end
            PH_WR2: begin
                if (pointer == PTR_MODE) begin
                    mode = d;
                    if (mode[MODE_SHUTDOWN] || mode[MODE_INTERRUPT]) drive_alert(1'b0);
                    load_fault_queue();
                    phase = PH_IDLE;
                end else if (pointer == PTR_OS) begin
                    ot_limit[15:8] = d;
                    phase = PH_WR3;
                end else if (pointer == PTR_HYST) begin
                    hyst_limit[15:8] = d;
                    phase = PH_WR3;
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_WR3: begin
                if (pointer == PTR_OS) ot_limit[7:0] = d;
                else if (pointer == PTR_HYST) hyst_limit[7:0] = d;
                phase = PH_IDLE;
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function logic [7:0] take_read();
        logic [7:0] r;
        r = 8'h00;
        if (mode[MODE_INTERRUPT]) drive_alert(1'b0);
        if (phase == PH_RD1) begin
            phase = PH_IDLE;
            case (pointer)
                PTR_TEMP: begin
                    r = temp_value[15:8];
                    phase = PH_RD2;
                end
                PTR_MODE: r = mode;
                PTR_OS: begin
                    r = ot_limit[15:8];
                    phase = PH_RD2;
                end
                PTR_HYST: begin
                    r = hyst_limit[15:8];
                    phase = PH_RD2;
                end
                PTR_ID: r = chip_id;
                default: r = 8'h00;
            endcase
        end else if (phase == PH_RD2) begin
            if (pointer == PTR_TEMP) r = temp_value[7:0];
            else if (pointer == PTR_OS) r = ot_limit[7:0];
            else if (pointer == PTR_HYST) r = hyst_limit[7:0];
            phase = PH_IDLE;
        end else begin
            phase = PH_IDLE;
        end
        return r;
    endfunction

    function void take_sample(logic [15:0] s);
        if (phase != PH_IDLE) return;
        temp_value = s;
        if (mode[MODE_SHUTDOWN]) return;
        if ($signed(s) > $signed(ot_limit)) begin
            fault_cnt = fault_cnt - 3'd1;
            if (fault_cnt == 3'd0) begin
                if (mode[MODE_INTERRUPT]) begin
                    if (!tripped_high) begin
                        drive_alert(1'b1);
                        tripped_high = 1'b1;
                        tripped_low = 1'b0;
                    end
                end else begin
                    drive_alert(1'b1);
                end
                fault_cnt = fault_reload;
            end
        end else if ($signed(s) < $signed(hyst_limit)) begin
            if (mode[MODE_INTERRUPT]) begin
                if (!tripped_low) begin
                    drive_alert(1'b1);
                    tripped_low = 1'b1;
                    tripped_high = 1'b0;
                end
            end else begin
                drive_alert(1'b0);
            end
            fault_cnt = fault_reload;
        end else begin
            fault_cnt = fault_reload;
        end
    endfunction

    function void apply_item(t_in_beat b);
        t_out_beat e;
        e.read_data = 8'h00;
        case (b.opcode)
            OP_START: phase = b.is_read ? PH_RD1 : PH_WR1;
            OP_WRITE: take_write(b.write_byte);
            OP_READ: e.read_data = take_read();
            default: take_sample(b.temperature_sample);
        endcase
        e.os_pull_low = pin_low;
        pending_results.push_back(e);
    endfunction

    function void check_result(t_out_beat got);
        t_out_beat e;
        if (pending_results.size() == 0) begin
            $error("unexpected result beat: read_data %02h os_pull_low %0b",
                   got.read_data, got.os_pull_low);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (got.read_data !== e.read_data) begin
            $error("read_data: expected %02h, actual %02h", e.read_data, got.read_data);
            errors++;
        end
        if (got.os_pull_low !== e.os_pull_low) begin
            $error("os_pull_low: expected %0b, actual %0b", e.os_pull_low, got.os_pull_low);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [ADDR_W-1:0] ID_ADDR = {REG_CHIP_ID, 2'b00};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_beat            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_beat           o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sensor_scoreboard sb;
    int items_sent = 0;
    int hold_left = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    i2c_temperature_sensor_thermostat DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (i_in_valid && !o_in_stall) sb.apply_item(i_in_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL i2c_temperature_sensor_thermostat");
            $finish;
        end
    end

    function automatic t_in_beat random_beat(logic [1:0] op);
        t_in_beat b;
        b.opcode = op;
        b.is_read = 1'($urandom_range(1));
        b.write_byte = 8'($urandom);
        b.temperature_sample = 16'($urandom);
        return b;
    endfunction

    task automatic send_item(t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_start(bit rd);
        t_in_beat b;
        b = random_beat(OP_START);
        b.is_read = rd;
        send_item(b);
    endtask

    task automatic send_write(logic [7:0] d);
        t_in_beat b;
        b = random_beat(OP_WRITE);
        b.write_byte = d;
        send_item(b);
    endtask

    task automatic send_read();
        send_item(random_beat(OP_READ));
    endtask

    task automatic send_sample(logic [15:0] s);
        t_in_beat b;
        b = random_beat(OP_CONVERT);
        b.temperature_sample = s;
        send_item(b);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.chip_id = data[7:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pointer();
        case ($urandom_range(6))
            0: return PTR_TEMP;
            1: return PTR_MODE;
            2: return PTR_HYST;
            3: return PTR_OS;
            4: return PTR_ID;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'(sb.ot_limit + 16'($urandom_range(8)) - 16'd3);
            4, 5, 6, 7: return 16'(sb.hyst_limit - 16'($urandom_range(8)) + 16'd3);
            8: return 16'($urandom);
            default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    task automatic random_sequence();
        int r;
        logic [7:0] p;
        logic [7:0] m;
        r = $urandom_range(99);
        if (r < 30) begin
            p = pick_pointer();
            send_start(1'b0);
            send_write(p);
            if (p == PTR_MODE) begin
                m = 8'($urandom);
                if ($urandom_range(7) != 0) m[MODE_SHUTDOWN] = 1'b0;
                send_write(m);
            end else if (p == PTR_OS || p == PTR_HYST) begin
                repeat (($urandom_range(3) == 0) ? 1 : 2) send_write(8'($urandom));
            end else if ($urandom_range(1)) begin
                send_write(8'($urandom));
            end
        end else if (r < 55) begin
            if ($urandom_range(1)) begin
                send_start(1'b0);
                send_write(pick_pointer());
            end
            send_start(1'b1);
            repeat ($urandom_range(1, 3)) send_read();
        end else if (r < 92) begin
            repeat ($urandom_range(1, 6)) send_sample(pick_sample());
        end else begin
            repeat ($urandom_range(1, 3)) send_item(random_beat(2'($urandom_range(3))));
        end
    endtask

    task automatic run_random_phase(int target, int idle_pct, int stall_pct);
        int stop_at;
        bit held;
        bit paused;
        stop_at = items_sent + target;
        held = 1'b0;
        paused = 1'b0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < stop_at) begin
            if (!held && items_sent > stop_at - target * 3 / 4) begin
                hold_left = 80;
                held = 1'b1;
            end
            if (!paused && items_sent > stop_at - target / 2) begin
                idle_input();
                wait_drained();
                paused = 1'b1;
            end
            random_sequence();
        end
        idle_input();
        wait_drained();
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_stall_pct = 20;
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_start(1'b0);
        send_write(PTR_OS);
        send_write(8'hFF);
        send_write(8'h00);
        send_start(1'b1);
        send_read();
        send_read();
        send_start(1'b0);
        send_write(PTR_MODE);
        send_write(8'h1E);
        send_start(1'b1);
        send_read();
        send_start(1'b0);
        send_write(PTR_ID);
        send_start(1'b1);
        send_read();
        send_read();
        send_write(8'h55);
        send_start(1'b0);
        send_write(8'h05);
        send_write(8'hAA);
        send_start(1'b0);
        send_sample(16'h1234);
        send_start(1'b0);
        send_write(PTR_MODE);
        send_write(8'h01);
        send_sample(16'h7FFF);
        idle_input();
        wait_drained();

        apb_write(ID_ADDR, 32'h0000_0000);
        run_random_phase(500, 13, 69);
        apb_write(ID_ADDR, 32'h0000_00FF);
        run_random_phase(500, 69, 13);
        apb_write(ID_ADDR, {24'h0, 8'($urandom)});
        run_random_phase(500, 0, 0);

        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("PASS i2c_temperature_sensor_thermostat");
        end else begin
            $display("FAIL i2c_temperature_sensor_thermostat");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/i2cts_pkg.sv
hw/rtl/i2cts_apb.sv
hw/rtl/i2cts_core.sv
hw/rtl/i2c_temperature_sensor_thermostat.sv
verif/tb.sv
